// ===== hw/rtl/byte_ring_fifo_overflow_policy_core_defines.svh =====
// ----------------------------------------------------------------------------
// byte ring fifo assertion macros
// concurrent assertion helpers, empty when synthesised
// ----------------------------------------------------------------------------
`ifndef BYTE_RING_FIFO_OVERFLOW_POLICY_CORE_DEFINES_SVH
`define BYTE_RING_FIFO_OVERFLOW_POLICY_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define BRF_ASSERT_HOLDS(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define BRF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BRF_ASSERT_HOLDS(label, clk, rst_n, ante, cons)
`define BRF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hw/rtl/brf_pkg.sv =====
// ----------------------------------------------------------------------------
// byte ring fifo package
// sizes, opcodes, status codes and state type shared by the ring fifo core
// ----------------------------------------------------------------------------
package brf_pkg;

    localparam int STORE_DEPTH  = 4096;
    localparam int MAX_RUN      = 64;
    localparam int MIN_CAPACITY = 64;

    localparam int PTR_W     = $clog2(STORE_DEPTH);
    localparam int CNT_W     = 13;
    localparam int RUN_W     = $clog2(MAX_RUN + 1);
    localparam int DATA_W    = 8;
    localparam int OPC_W     = 3;
    localparam int STAT_W    = 3;
    localparam int CFG_IDX_W = 1;

    localparam logic [OPC_W-1:0] OP_WRITE = 3'd0;
    localparam logic [OPC_W-1:0] OP_READ  = 3'd1;
    localparam logic [OPC_W-1:0] OP_PEEK  = 3'd2;
    localparam logic [OPC_W-1:0] OP_SKIP  = 3'd3;
    localparam logic [OPC_W-1:0] OP_CLEAR = 3'd4;

    localparam logic [STAT_W-1:0] ST_DONE      = 3'd0;
    localparam logic [STAT_W-1:0] ST_OVERWRITE = 3'd1;
    localparam logic [STAT_W-1:0] ST_DROPPED   = 3'd2;
    localparam logic [STAT_W-1:0] ST_REJECTED  = 3'd3;
    localparam logic [STAT_W-1:0] ST_UNDERRUN  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OVERWRITE = 1'd1;

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

endpackage

// ===== hw/rtl/byte_ring_fifo_overflow_policy_core.sv =====
// ----------------------------------------------------------------------------
// byte ring fifo with overflow policy
// Requests arrive on the input channel (valid/stall): write byte, read run,
// peek run, skip and clear. Results leave on the output channel (valid/stall)
// through one output register. Configuration (capacity, overwrite policy) is
// written through a valid/ready port that is always ready.
// Write, skip and clear take one cycle each and give one result a cycle
// after acceptance, so a chunk streams in at one byte per cycle.
// A read or peek of n bytes starts its first ram read in the accept cycle,
// then one byte leaves per cycle while the output is not stalled, paced by
// the single registered read port of the byte store. Underrun gives one result.
// Input is stalled while a run is in progress or the output register is
// full and stalled. A stalled output holds its result and the run pauses.
// Reset empties the fifo, sets capacity to 4096 and overwrite mode; the byte
// store has no clearing pass and accepts requests straight after reset.
// ----------------------------------------------------------------------------
`include "byte_ring_fifo_overflow_policy_core_defines.svh"

module byte_ring_fifo_overflow_policy_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [brf_pkg::OPC_W-1:0]     i_opcode,
    input  logic [brf_pkg::DATA_W-1:0]    i_data_byte,
    input  logic                          i_end_of_chunk,
    input  logic [brf_pkg::CNT_W-1:0]     i_amount,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [brf_pkg::DATA_W-1:0]    o_out_byte,
    output logic                          o_last_of_run,
    output logic [brf_pkg::STAT_W-1:0]    o_status,
    output logic [brf_pkg::CNT_W-1:0]     o_fill_level,
    output logic [brf_pkg::CNT_W-1:0]     o_moved_count,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [brf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [brf_pkg::CNT_W-1:0]     i_cfg_data
);

    import brf_pkg::*;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p,
                                              input logic [CNT_W-1:0] cap);
        logic [CNT_W-1:0] nx;
        nx = CNT_W'(p) + CNT_W'(1);
        return (nx >= cap) ? '0 : nx[PTR_W-1:0];
    endfunction

    t_state r_state, n_state;

    logic [CNT_W-1:0]  r_cap;
    logic              r_ovw;
    logic [PTR_W-1:0]  r_wptr, n_wptr;
    logic [PTR_W-1:0]  r_rptr, n_rptr;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_pos, n_pos;
    logic              r_refused, n_refused;

    logic [PTR_W-1:0]  r_p, n_p;
    logic [RUN_W-1:0]  r_k, n_k;
    logic [RUN_W-1:0]  r_n, n_n;
    logic [CNT_W-1:0]  r_fill, n_fill;
    logic              r_is_read, n_is_read;

    logic              r_out_valid, n_out_valid;
    logic [DATA_W-1:0] r_out_byte, n_out_byte;
    logic              r_out_last, n_out_last;
    logic [STAT_W-1:0] r_out_status, n_out_status;
    logic [CNT_W-1:0]  r_out_fill, n_out_fill;
    logic [CNT_W-1:0]  r_out_moved, n_out_moved;

    logic              ram_we;
    logic [PTR_W-1:0]  ram_waddr;
    logic              ram_re;
    logic [PTR_W-1:0]  ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    logic              out_free;
    logic              in_accept;
    logic              cfg_write;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = !((r_state == S_IDLE) && out_free);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;

    brf_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_data_byte),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        logic             full;
        logic             store;
        logic [CNT_W-1:0] pos_after;
        logic [RUN_W-1:0] amt_run;
        logic [RUN_W-1:0] run_n;
        logic [CNT_W-1:0] skip_s;
        logic [CNT_W-1:0] skip_sum;

        full      = r_count >= r_cap;
        store     = 1'b0;
        pos_after = r_pos;
        amt_run   = (i_amount > CNT_W'(MAX_RUN)) ? RUN_W'(MAX_RUN) : i_amount[RUN_W-1:0];
        run_n     = (CNT_W'(amt_run) > r_count) ? r_count[RUN_W-1:0] : amt_run;
        skip_s    = (i_amount < r_count) ? i_amount : r_count;
        skip_sum  = CNT_W'(r_rptr) + skip_s;
        if (skip_sum >= r_cap) begin
            skip_sum = skip_sum - r_cap;
        end

        n_state      = r_state;
        n_wptr       = r_wptr;
        n_rptr       = r_rptr;
        n_count      = r_count;
        n_pos        = r_pos;
        n_refused    = r_refused;
        n_p          = r_p;
        n_k          = r_k;
        n_n          = r_n;
        n_fill       = r_fill;
        n_is_read    = r_is_read;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_byte   = r_out_byte;
        n_out_last   = r_out_last;
        n_out_status = r_out_status;
        n_out_fill   = r_out_fill;
        n_out_moved  = r_out_moved;
        ram_we       = 1'b0;
        ram_waddr    = r_wptr;
        ram_re       = 1'b0;
        ram_raddr    = r_rptr;

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    unique case (i_opcode) inside
                        OP_WRITE: begin
                            n_out_status = ST_DONE;
                            if (r_refused) begin
                                n_out_status = ST_REJECTED;
                            end else if (r_pos >= r_cap) begin
                                n_out_status = ST_DROPPED;
                            end else if (full && !r_ovw) begin
                                if (r_pos == '0) begin
                                    n_refused    = 1'b1;
                                    n_out_status = ST_REJECTED;
                                end else begin
                                    n_out_status = ST_DROPPED;
                                end
                            end else if (full) begin
                                n_rptr       = bump(r_rptr, r_cap);
                                n_out_status = ST_OVERWRITE;
                                store        = 1'b1;
                            end else begin
                                n_count = r_count + CNT_W'(1);
                                store   = 1'b1;
                            end
                            if (store) begin
                                ram_we = 1'b1;
                                n_wptr = bump(r_wptr, r_cap);
                            end
                            if (!n_refused && (r_pos < r_cap)) begin
                                pos_after = r_pos + CNT_W'(1);
                            end
                            n_out_valid = 1'b1;
                            n_out_byte  = '0;
                            n_out_last  = 1'b1;
                            n_out_fill  = n_count;
                            n_out_moved = pos_after;
                            if (i_end_of_chunk) begin
                                n_pos     = '0;
                                n_refused = 1'b0;
                            end else begin
                                n_pos = pos_after;
                            end
                        end
                        OP_READ, OP_PEEK: begin
                            if (run_n == '0) begin
                                n_out_valid  = 1'b1;
                                n_out_byte   = '0;
                                n_out_last   = 1'b1;
                                n_out_status = ST_UNDERRUN;
                                n_out_fill   = r_count;
                                n_out_moved  = '0;
                            end else begin
                                ram_re    = 1'b1;
                                ram_raddr = r_rptr;
                                n_p       = bump(r_rptr, r_cap);
                                n_k       = RUN_W'(1);
                                n_n       = run_n;
                                n_is_read = (i_opcode == OP_READ);
                                if (i_opcode == OP_READ) begin
                                    n_count = r_count - CNT_W'(run_n);
                                    n_fill  = r_count - CNT_W'(run_n);
                                end else begin
                                    n_fill = r_count;
                                end
                                n_state = S_RUN;
                            end
                        end
                        OP_SKIP: begin
                            n_rptr       = skip_sum[PTR_W-1:0];
                            n_count      = r_count - skip_s;
                            n_out_valid  = 1'b1;
                            n_out_byte   = '0;
                            n_out_last   = 1'b1;
                            n_out_status = ST_DONE;
                            n_out_fill   = r_count - skip_s;
                            n_out_moved  = skip_s;
                        end
                        OP_CLEAR: begin
                            n_wptr       = '0;
                            n_rptr       = '0;
                            n_count      = '0;
                            n_pos        = '0;
                            n_refused    = 1'b0;
                            n_out_valid  = 1'b1;
                            n_out_byte   = '0;
                            n_out_last   = 1'b1;
                            n_out_status = ST_DONE;
                            n_out_fill   = '0;
                            n_out_moved  = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RUN: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_byte   = ram_rdata;
                    n_out_last   = (r_k == r_n);
                    n_out_status = ST_DONE;
                    n_out_fill   = r_fill;
                    n_out_moved  = CNT_W'(r_k);
                    if (r_k == r_n) begin
                        if (r_is_read) begin
                            n_rptr = r_p;
                        end
                        n_state = S_IDLE;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = r_p;
                        n_p       = bump(r_p, r_cap);
                        n_k       = r_k + RUN_W'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wptr      <= '0;
            r_rptr      <= '0;
            r_count     <= '0;
            r_pos       <= '0;
            r_refused   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wptr      <= n_wptr;
            r_rptr      <= n_rptr;
            r_count     <= n_count;
            r_pos       <= n_pos;
            r_refused   <= n_refused;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p          <= n_p;
        r_k          <= n_k;
        r_n          <= n_n;
        r_fill       <= n_fill;
        r_is_read    <= n_is_read;
        r_out_byte   <= n_out_byte;
        r_out_last   <= n_out_last;
        r_out_status <= n_out_status;
        r_out_fill   <= n_out_fill;
        r_out_moved  <= n_out_moved;
    end

    // capacity is clamped on write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CNT_W'(STORE_DEPTH);
            r_ovw <= 1'b1;
        end else if (cfg_write) begin
            unique case (i_cfg_index)
                REG_CAPACITY: begin
                    if (i_cfg_data < CNT_W'(MIN_CAPACITY)) begin
                        r_cap <= CNT_W'(MIN_CAPACITY);
                    end else if (i_cfg_data > CNT_W'(STORE_DEPTH)) begin
                        r_cap <= CNT_W'(STORE_DEPTH);
                    end else begin
                        r_cap <= i_cfg_data;
                    end
                end
                REG_OVERWRITE: begin
                    r_ovw <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_last_of_run = r_out_last;
    assign o_status      = r_out_status;
    assign o_fill_level  = r_out_fill;
    assign o_moved_count = r_out_moved;

    `BRF_ASSERT_HOLDS(a_run_index, i_clk, i_rst_n, r_state == S_RUN,
        (r_k != '0) && (r_k <= r_n) && (r_n <= RUN_W'(MAX_RUN)))
    `BRF_ASSERT_NEXT(a_run_ends, i_clk, i_rst_n,
        (r_state == S_RUN) && out_free && (r_k == r_n),
        (r_state == S_IDLE) && o_out_valid && o_last_of_run)
    `BRF_ASSERT_NEXT(a_write_result, i_clk, i_rst_n, in_accept && (i_opcode == OP_WRITE),
        o_out_valid && o_last_of_run && (o_out_byte == '0))

endmodule

// ===== hw/rtl/brf_ram.sv =====
// ----------------------------------------------------------------------------
// generic ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module brf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
